// File: rtl/core/tsac_pkg.sv
// tsac_pkg: widths, register indexes, reset values and shared types for the
// touch sample averaging and calibration block; no dependencies

package tsac_pkg;

  localparam int RAW_W       = 16;
  localparam int DIV_W       = 16;
  localparam int OFS_W       = 11;
  localparam int GAIN_W      = 16;
  localparam int CX_W        = 8;
  localparam int CY_W        = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int SAMPLES_DEF = 16;
  localparam int FRAC_BITS   = 12;

  // signed value before scaling and the exact product
  localparam int V_W         = 18;
  localparam int PROD_W      = V_W + GAIN_W;

  localparam int X_SPAN      = 240;
  localparam int X_TOP       = 239;
  localparam int Y_TOP       = 319;

  localparam logic [CFG_IDX_W-1:0] REG_X_DIVISOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_DIVISOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_GAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN    = 3'd5;

  localparam logic [DIV_W-1:0]  DIVISOR_RST = 16'd128;
  localparam logic [OFS_W-1:0]  OFFSET_RST  = 11'd0;
  localparam logic [GAIN_W-1:0] GAIN_RST    = 16'd4096;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_NOISY = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: rtl/core/tsac_if.sv
// tsac_if: valid/ready channels for raw sample items and coordinate result items
// depends on tsac_pkg for field widths

interface tsac_sample_if;
  logic                         valid;
  logic                         ready;
  logic [tsac_pkg::RAW_W-1:0]   raw_x;
  logic [tsac_pkg::RAW_W-1:0]   raw_y;
  logic                         pen_down;

  modport source (output valid, raw_x, raw_y, pen_down, input ready);
  modport sink   (input valid, raw_x, raw_y, pen_down, output ready);
endinterface

interface tsac_result_if;
  logic                         valid;
  logic                         ready;
  logic [tsac_pkg::CX_W-1:0]    coord_x;
  logic [tsac_pkg::CY_W-1:0]    coord_y;
  logic                         status;

  modport source (output valid, coord_x, coord_y, status, input ready);
  modport sink   (input valid, coord_x, coord_y, status, output ready);
endinterface

// File: rtl/core/tsac_div.sv
// tsac_div: restoring divider, one quotient bit per cycle
// depends on tsac_pkg; a zero divisor gives an all-ones quotient

module tsac_div #(
  parameter int DW = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DW-1:0]              dividend,
  input  logic [tsac_pkg::DIV_W-1:0] divisor,
  output tsac_pkg::unit_stat_t       stat,
  output logic [DW-1:0]              quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0]              shreg;
  logic [tsac_pkg::DIV_W-1:0] rem;
  logic [tsac_pkg::DIV_W-1:0] dsr;
  logic [CW-1:0]              cnt;
  logic                       busy;
  logic                       done;
  logic [tsac_pkg::DIV_W:0]   trial;
  logic                       fits;

  assign trial = {rem, shreg[DW-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in at the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dsr   <= divisor;
    end else if (busy) begin
      shreg <= {shreg[DW-2:0], fits};
      rem   <= fits ? tsac_pkg::DIV_W'(trial - {1'b0, dsr}) : trial[tsac_pkg::DIV_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = shreg;

endmodule

// File: rtl/core/tsac_mul.sv
// tsac_mul: shift-add multiplier, signed value by unsigned gain, one gain bit per cycle
// depends on tsac_pkg

module tsac_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [tsac_pkg::V_W-1:0]    mcand,
  input  logic [tsac_pkg::GAIN_W-1:0]        mplier,
  output tsac_pkg::unit_stat_t               stat,
  output logic signed [tsac_pkg::PROD_W-1:0] product
);

  localparam int CW = $clog2(tsac_pkg::GAIN_W + 1);

  logic signed [tsac_pkg::PROD_W-1:0] acc;
  logic signed [tsac_pkg::PROD_W-1:0] addend;
  logic [tsac_pkg::GAIN_W-1:0]        msr;
  logic [CW-1:0]                      cnt;
  logic                               busy;
  logic                               done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(tsac_pkg::GAIN_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      addend <= {{(tsac_pkg::PROD_W - tsac_pkg::V_W){mcand[tsac_pkg::V_W-1]}}, mcand};
      msr    <= mplier;
    end else if (busy) begin
      if (msr[0]) begin
        acc <= acc + addend;
      end
      addend <= addend <<< 1;
      msr    <= msr >> 1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign product   = acc;

endmodule

// File: rtl/core/touch_sample_average_calibrate.sv
// touch_sample_average_calibrate: top level, burst averaging and per-axis calibration
// depends on tsac_pkg, tsac_if, tsac_div and tsac_mul
//
// usage: raw sample items (raw_x, raw_y, pen_down) enter on the sample channel,
// coordinate items (coord_x, coord_y, status) leave on the result channel, both
// valid/ready. configuration is a write-only port (cfg_write, cfg_index, cfg_data)
// to be used while the block is idle.
// a pen-down item during a burst is summed and gives no result;
// a pen-up item gives a noisy result the next cycle. the item after SAMPLES pen-down
// items is the final pen check: if the pen is still down, the block runs a shared
// bit-serial divider twice and a bit-serial multiplier once per axis, X then Y.
// no item is taken while this runs. the result sits in an output register; a new item
// is taken while it waits only if the receiver takes it in the same cycle, so a
// stalled receiver holds the result and stalls the sample side.
// reset (rst, synchronous) clears the sums, the count and the result valid flag and
// loads the default divisors, offsets and gains.

module touch_sample_average_calibrate #(
  parameter int SAMPLES = tsac_pkg::SAMPLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  tsac_sample_if.sink                     sample,
  tsac_result_if.source                   result,
  input  logic                            cfg_write,
  input  logic [tsac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsac_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SW = tsac_pkg::RAW_W + $clog2(SAMPLES);
  localparam int CW = $clog2(SAMPLES + 1);

  localparam logic [1:0] S_COLLECT = 2'd0;
  localparam logic [1:0] S_AVG     = 2'd1;
  localparam logic [1:0] S_QUO     = 2'd2;
  localparam logic [1:0] S_MUL     = 2'd3;

  logic [1:0]                    state;
  logic                          axis;
  logic                          go;
  logic [SW-1:0]                 sum_x;
  logic [SW-1:0]                 sum_y;
  logic [CW-1:0]                 count;

  logic [tsac_pkg::DIV_W-1:0]    x_divisor;
  logic [tsac_pkg::DIV_W-1:0]    y_divisor;
  logic [tsac_pkg::OFS_W-1:0]    x_offset;
  logic [tsac_pkg::OFS_W-1:0]    y_offset;
  logic [tsac_pkg::GAIN_W-1:0]   x_gain;
  logic [tsac_pkg::GAIN_W-1:0]   y_gain;

  logic                          res_valid;
  logic [tsac_pkg::CX_W-1:0]     res_x;
  logic [tsac_pkg::CY_W-1:0]     res_y;
  logic                          res_status;

  logic [tsac_pkg::RAW_W-1:0]    avg;
  logic [tsac_pkg::RAW_W-1:0]    inv;
  logic [tsac_pkg::DIV_W-1:0]    quo;
  logic [tsac_pkg::CX_W-1:0]     cx_hold;

  logic                          take;
  logic                          full;
  logic                          div_start;
  logic                          mul_start;
  logic [SW-1:0]                 div_dividend;
  logic [tsac_pkg::DIV_W-1:0]    div_divisor;
  logic [SW-1:0]                 div_q;
  tsac_pkg::unit_stat_t          div_st;
  tsac_pkg::unit_stat_t          mul_st;

  logic signed [tsac_pkg::V_W-1:0]    ofs_ext;
  logic signed [tsac_pkg::V_W-1:0]    quo_ext;
  logic signed [tsac_pkg::V_W-1:0]    value;
  logic [tsac_pkg::GAIN_W-1:0]        gain;
  logic signed [tsac_pkg::PROD_W-1:0] prod;
  logic [tsac_pkg::PROD_W-2-tsac_pkg::FRAC_BITS:0] scaled;
  logic [tsac_pkg::CY_W-1:0]          top;
  logic [tsac_pkg::CY_W-1:0]          clamped;

  assign sample.ready = (state == S_COLLECT) && (!res_valid || result.ready);
  assign take         = sample.valid && sample.ready;
  assign full         = count == CW'(SAMPLES);
  assign div_start    = go && (state != S_MUL);
  assign mul_start    = go && (state == S_MUL);

  assign inv = tsac_pkg::RAW_W'(~avg + 1'b1);

  always_comb begin
    if (state == S_AVG) begin
      div_dividend = axis ? sum_y : sum_x;
      div_divisor  = tsac_pkg::DIV_W'(SAMPLES);
    end else begin
      div_dividend = {{(SW - tsac_pkg::RAW_W){1'b0}}, inv};
      div_divisor  = axis ? y_divisor : x_divisor;
    end
  end

  // X: 240 - q - offset, Y: q - offset, exact in 18 signed bits
  assign ofs_ext = axis ? {{(tsac_pkg::V_W - tsac_pkg::OFS_W){y_offset[tsac_pkg::OFS_W-1]}}, y_offset}
                        : {{(tsac_pkg::V_W - tsac_pkg::OFS_W){x_offset[tsac_pkg::OFS_W-1]}}, x_offset};
  assign quo_ext = {{(tsac_pkg::V_W - tsac_pkg::DIV_W){1'b0}}, quo};
  assign value   = axis ? (quo_ext - ofs_ext)
                        : (tsac_pkg::V_W'(tsac_pkg::X_SPAN) - quo_ext - ofs_ext);
  assign gain    = axis ? y_gain : x_gain;

  assign scaled  = prod[tsac_pkg::PROD_W-2:tsac_pkg::FRAC_BITS];
  assign top     = axis ? tsac_pkg::CY_W'(tsac_pkg::Y_TOP) : tsac_pkg::CY_W'(tsac_pkg::X_TOP);

  always_comb begin
    if (prod[tsac_pkg::PROD_W-1]) begin
      clamped = '0;
    end else if (scaled > {{($bits(scaled) - tsac_pkg::CY_W){1'b0}}, top}) begin
      clamped = top;
    end else begin
      clamped = scaled[tsac_pkg::CY_W-1:0];
    end
  end

  tsac_div #(
    .DW (SW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_st),
    .quotient (div_q)
  );

  tsac_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (value),
    .mplier  (gain),
    .stat    (mul_st),
    .product (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_COLLECT;
      axis      <= 1'b0;
      go        <= 1'b0;
      sum_x     <= '0;
      sum_y     <= '0;
      count     <= '0;
      res_valid <= 1'b0;
      x_divisor <= tsac_pkg::DIVISOR_RST;
      y_divisor <= tsac_pkg::DIVISOR_RST;
      x_offset  <= tsac_pkg::OFFSET_RST;
      y_offset  <= tsac_pkg::OFFSET_RST;
      x_gain    <= tsac_pkg::GAIN_RST;
      y_gain    <= tsac_pkg::GAIN_RST;
    end else begin
      go <= 1'b0;
      if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end

      if (cfg_write) begin
        case (cfg_index)
          tsac_pkg::REG_X_DIVISOR: x_divisor <= cfg_data;
          tsac_pkg::REG_Y_DIVISOR: y_divisor <= cfg_data;
          tsac_pkg::REG_X_OFFSET:  x_offset  <= cfg_data[tsac_pkg::OFS_W-1:0];
          tsac_pkg::REG_Y_OFFSET:  y_offset  <= cfg_data[tsac_pkg::OFS_W-1:0];
          tsac_pkg::REG_X_GAIN:    x_gain    <= cfg_data;
          tsac_pkg::REG_Y_GAIN:    y_gain    <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_COLLECT: begin
          if (take) begin
            if (!sample.pen_down) begin
              sum_x     <= '0;
              sum_y     <= '0;
              count     <= '0;
              res_valid <= 1'b1;
            end else if (!full) begin
              sum_x <= sum_x + SW'(sample.raw_x);
              sum_y <= sum_y + SW'(sample.raw_y);
              count <= count + 1'b1;
            end else begin
              axis  <= 1'b0;
              go    <= 1'b1;
              state <= S_AVG;
            end
          end
        end
        S_AVG: begin
          if (div_st.done) begin
            go    <= 1'b1;
            state <= S_QUO;
          end
        end
        S_QUO: begin
          if (div_st.done) begin
            go    <= 1'b1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_st.done) begin
            if (axis) begin
              sum_x     <= '0;
              sum_y     <= '0;
              count     <= '0;
              res_valid <= 1'b1;
              state     <= S_COLLECT;
            end else begin
              axis  <= 1'b1;
              go    <= 1'b1;
              state <= S_AVG;
            end
          end
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_COLLECT && take && !sample.pen_down) begin
      res_x      <= '0;
      res_y      <= '0;
      res_status <= tsac_pkg::STATUS_NOISY;
    end
    if (state == S_AVG && div_st.done) begin
      avg <= div_q[tsac_pkg::RAW_W-1:0];
    end
    if (state == S_QUO && div_st.done) begin
      quo <= div_q[tsac_pkg::DIV_W-1:0];
    end
    if (state == S_MUL && mul_st.done) begin
      if (axis) begin
        res_x      <= cx_hold;
        res_y      <= clamped;
        res_status <= tsac_pkg::STATUS_OK;
      end else begin
        cx_hold <= clamped[tsac_pkg::CX_W-1:0];
      end
    end
  end

  assign result.valid   = res_valid;
  assign result.coord_x = res_x;
  assign result.coord_y = res_y;
  assign result.status  = res_status;

`ifndef NO_ASSERTIONS
  // a noisy result never carries coordinates
  a_noisy_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status |-> res_x == '0 && res_y == '0)
    else $error("noisy result with nonzero coordinates");

  a_on_screen: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_x <= tsac_pkg::CX_W'(tsac_pkg::X_TOP)
               && res_y <= tsac_pkg::CY_W'(tsac_pkg::Y_TOP))
    else $error("coordinate beyond screen");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(SAMPLES))
    else $error("sample count beyond burst length");

  // the shared divider and multiplier take turns
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(div_st.busy && mul_st.busy))
    else $error("divider and multiplier busy together");

  a_burst_cleared: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL && mul_st.done && axis |=> count == '0 && sum_x == '0 && res_valid)
    else $error("burst not cleared after ok result");
`endif

endmodule

// File: sim/tsac_point_checker.sv
// tsac_point_checker: watches the sample, result and register ports of the touch
// averaging block, predicts every coordinate item and compares it field by field
// depends on tsac_pkg and the tsac_sample_if / tsac_result_if interfaces
`timescale 1ns / 1ps

module tsac_point_checker (
  input  logic                            clk,
  input  logic                            rst,
  tsac_sample_if                          smp,
  tsac_result_if                          res,
  input  logic                            cfg_write,
  input  logic [tsac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsac_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              errors,
  output int                              pending,
  output int                              ok_seen,
  output int                              noisy_seen
);

  localparam int BURST = tsac_pkg::SAMPLES_DEF;
  localparam int SUM_W = tsac_pkg::RAW_W + $clog2(BURST);

  typedef struct packed {
    logic [tsac_pkg::CX_W-1:0] cx;
    logic [tsac_pkg::CY_W-1:0] cy;
    logic                      st;
  } touch_point_t;

  touch_point_t points_due[$];

  // shadow of the calibration registers
  logic        [tsac_pkg::DIV_W-1:0]  x_div, y_div;
  logic signed [tsac_pkg::OFS_W-1:0]  x_off, y_off;
  logic        [tsac_pkg::GAIN_W-1:0] x_gain, y_gain;

  // burst accumulation
  logic [SUM_W-1:0] sum_x, sum_y;
  logic [4:0]       burst_cnt;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [tsac_pkg::RAW_W-1:0] axis_quotient(
      input logic [SUM_W-1:0] sum, input logic [tsac_pkg::DIV_W-1:0] div);
    logic [tsac_pkg::RAW_W-1:0] mean, flipped;
    mean    = tsac_pkg::RAW_W'(sum / BURST);
    flipped = '0 - mean;
    // zero divisor saturates like an all-ones serial divider
    if (div == '0) return '1;
    return flipped / div;
  endfunction

  function automatic int scale_clamp(input longint v,
                                     input logic [tsac_pkg::GAIN_W-1:0] gain,
                                     input int top);
    longint prod;
    prod = v * longint'(gain);
    if (prod < 0) return 0;
    prod = prod >>> tsac_pkg::FRAC_BITS;
    return (prod > top) ? top : int'(prod);
  endfunction

  task automatic apply_reg(input logic [tsac_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tsac_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      tsac_pkg::REG_X_DIVISOR: x_div  = val[tsac_pkg::DIV_W-1:0];
      tsac_pkg::REG_Y_DIVISOR: y_div  = val[tsac_pkg::DIV_W-1:0];
      tsac_pkg::REG_X_OFFSET:  x_off  = $signed(val[tsac_pkg::OFS_W-1:0]);
      tsac_pkg::REG_Y_OFFSET:  y_off  = $signed(val[tsac_pkg::OFS_W-1:0]);
      tsac_pkg::REG_X_GAIN:    x_gain = val[tsac_pkg::GAIN_W-1:0];
      tsac_pkg::REG_Y_GAIN:    y_gain = val[tsac_pkg::GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic predict_touch(input logic [tsac_pkg::RAW_W-1:0] rx,
                               input logic [tsac_pkg::RAW_W-1:0] ry,
                               input logic pen);
    touch_point_t pt;
    longint vx, vy;
    pt.cx = '0;
    pt.cy = '0;
    pt.st = tsac_pkg::STATUS_NOISY;
    if (burst_cnt < BURST) begin
      if (pen) begin
        sum_x     += SUM_W'(rx);
        sum_y     += SUM_W'(ry);
        burst_cnt++;
        return;
      end
    end else if (pen) begin
      // pen still down on the check item: raw words of this item are ignored
      vx = longint'(tsac_pkg::X_SPAN) - longint'(axis_quotient(sum_x, x_div))
           - longint'(x_off);
      vy = longint'(axis_quotient(sum_y, y_div)) - longint'(y_off);
      pt.cx = tsac_pkg::CX_W'(scale_clamp(vx, x_gain, tsac_pkg::X_TOP));
      pt.cy = tsac_pkg::CY_W'(scale_clamp(vy, y_gain, tsac_pkg::Y_TOP));
      pt.st = tsac_pkg::STATUS_OK;
    end
    sum_x     = '0;
    sum_y     = '0;
    burst_cnt = '0;
    points_due.push_back(pt);
  endtask

  task automatic check_point(input logic [tsac_pkg::CX_W-1:0] cx,
                             input logic [tsac_pkg::CY_W-1:0] cy,
                             input logic st);
    touch_point_t want;
    if (points_due.size() == 0) begin
      report_mismatch($sformatf("unexpected point x=%0d y=%0d status=%0b", cx, cy, st));
      return;
    end
    want = points_due.pop_front();
    if (cx !== want.cx)
      report_mismatch($sformatf("coord_x got %0d want %0d", cx, want.cx));
    if (cy !== want.cy)
      report_mismatch($sformatf("coord_y got %0d want %0d", cy, want.cy));
    if (st !== want.st)
      report_mismatch($sformatf("status got %0b want %0b", st, want.st));
    if (want.st == tsac_pkg::STATUS_OK) ok_seen++;
    else noisy_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      x_div     = tsac_pkg::DIVISOR_RST;
      y_div     = tsac_pkg::DIVISOR_RST;
      x_off     = tsac_pkg::OFFSET_RST;
      y_off     = tsac_pkg::OFFSET_RST;
      x_gain    = tsac_pkg::GAIN_RST;
      y_gain    = tsac_pkg::GAIN_RST;
      sum_x     = '0;
      sum_y     = '0;
      burst_cnt = '0;
      points_due.delete();
    end else begin
      if (cfg_write) apply_reg(cfg_index, cfg_data);
      // a result leaving now always belongs to an earlier item
      if (res.valid && res.ready) check_point(res.coord_x, res.coord_y, res.status);
      if (smp.valid && smp.ready) predict_touch(smp.raw_x, smp.raw_y, smp.pen_down);
    end
    pending <= points_due.size();
  end

endmodule

// File: sim/touch_sample_average_calibrate_tb.sv
// touch_sample_average_calibrate_tb: drives sample bursts, register settings and
// receiver stalls into the block; tsac_point_checker does the prediction
// depends on tsac_pkg, tsac_if, the block and tsac_point_checker
`timescale 1ns / 1ps

module touch_sample_average_calibrate_tb;

  localparam int BURST       = tsac_pkg::SAMPLES_DEF;
  localparam int LATENCY     = 140;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT       = 500000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 80;

  localparam logic [tsac_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [tsac_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [tsac_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tsac_pkg::CFG_DATA_W-1:0] cfg_data;

  int errors, pending, ok_seen, noisy_seen;
  int send_pct, stall_pct;
  int hold_req, hold_seen;
  int items_sent, bursts_done, cycle_cnt;

  tsac_sample_if smp ();
  tsac_result_if res ();

  touch_sample_average_calibrate dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (smp),
    .result    (res),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tsac_point_checker chk (
    .clk        (clk),
    .rst        (rst),
    .smp        (smp),
    .res        (res),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending),
    .ok_seen    (ok_seen),
    .noisy_seen (noisy_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d points still due", LIMIT, pending);
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    res.ready <= 1'b0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_item(input logic [tsac_pkg::RAW_W-1:0] rx,
                           input logic [tsac_pkg::RAW_W-1:0] ry,
                           input logic pen);
    if ($urandom_range(99) < send_pct) begin
      smp.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    smp.valid    <= 1'b1;
    smp.raw_x    <= rx;
    smp.raw_y    <= ry;
    smp.pen_down <= pen;
    do @(posedge clk); while (!smp.ready);
    items_sent++;
  endtask

  // mostly readings near the upper rail, where the calibration lands on screen
  function automatic logic [tsac_pkg::RAW_W-1:0] pick_raw();
    if ($urandom_range(3) == 0) return tsac_pkg::RAW_W'($urandom);
    return tsac_pkg::RAW_W'(16'hFFFF - $urandom_range(30000));
  endfunction

  task automatic wait_drained();
    smp.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // a summed item or the divider may still be busy
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tsac_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tsac_pkg::CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [tsac_pkg::DIV_W-1:0] dx,
                             input logic [tsac_pkg::DIV_W-1:0] dy,
                             input logic [tsac_pkg::OFS_W-1:0] ox,
                             input logic [tsac_pkg::OFS_W-1:0] oy,
                             input logic [tsac_pkg::GAIN_W-1:0] gx,
                             input logic [tsac_pkg::GAIN_W-1:0] gy);
    write_reg(tsac_pkg::REG_X_DIVISOR, dx);
    write_reg(tsac_pkg::REG_Y_DIVISOR, dy);
    // junk above the offset width must be dropped
    write_reg(tsac_pkg::REG_X_OFFSET, {5'($urandom), ox});
    write_reg(tsac_pkg::REG_Y_OFFSET, {5'($urandom), oy});
    write_reg(tsac_pkg::REG_X_GAIN, gx);
    write_reg(tsac_pkg::REG_Y_GAIN, gy);
    write_reg(REG_SPARE_LO, tsac_pkg::CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_HI, tsac_pkg::CFG_DATA_W'($urandom));
    cfg_write <= 1'b0;
  endtask

  task automatic run_random(input int n_items);
    int   sent, cut, i;
    logic pen;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: begin
          send_item(pick_raw(), pick_raw(), $urandom_range(3) == 0);
          sent++;
        end
        1, 2: begin
          // burst broken by a lifted pen
          cut = $urandom_range(BURST - 1);
          for (i = 0; i < cut; i++) send_item(pick_raw(), pick_raw(), 1'b1);
          send_item(pick_raw(), pick_raw(), 1'b0);
          sent += cut + 1;
        end
        default: begin
          for (i = 0; i < BURST; i++) send_item(pick_raw(), pick_raw(), 1'b1);
          // first full burst ends with the pen lifted on the check item
          pen = (bursts_done == 0) ? 1'b0 : ($urandom_range(4) != 0);
          send_item(tsac_pkg::RAW_W'($urandom), tsac_pkg::RAW_W'($urandom), pen);
          bursts_done++;
          sent += BURST + 1;
        end
      endcase
    end
  endtask

  initial begin
    int i, ph;
    rst          <= 1'b1;
    smp.valid    <= 1'b0;
    smp.raw_x    <= '0;
    smp.raw_y    <= '0;
    smp.pen_down <= 1'b0;
    cfg_write    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    send_pct     = 0;
    stall_pct    <= 0;
    hold_req     <= 0;
    items_sent   = 0;
    bursts_done  = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // pen lifted with nothing collected
    send_item(16'h0000, 16'hFFFF, 1'b0);
    // burst aborted after three readings
    for (i = 0; i < 3; i++) send_item(16'hFFFF, 16'h0000, 1'b1);
    send_item(16'h1234, 16'hABCD, 1'b0);
    // full burst at both rails, then the pen check
    for (i = 0; i < BURST; i++)
      send_item((i < BURST / 2) ? 16'hFFFF : 16'h0000,
                (i < BURST / 2) ? 16'h0000 : 16'hFFFF, 1'b1);
    send_item(16'h0000, 16'h0000, 1'b1);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: load_config(16'd1, 16'd1, 11'h400, 11'h3FF, 16'd0, 16'hFFFF);
        1: load_config(16'hFFFF, 16'hFFFF, 11'h3FF, 11'h400, 16'hFFFF, 16'd0);
        2: load_config(16'd0, 16'd0, 11'($urandom), 11'($urandom),
                       tsac_pkg::GAIN_RST, tsac_pkg::GAIN_RST);
        default: load_config(16'($urandom_range(2048, 16)), 16'($urandom_range(2048, 16)),
                             11'($urandom), 11'($urandom),
                             16'($urandom_range(16384, 1024)), 16'($urandom));
      endcase
      case (ph % 4)
        0: begin send_pct = 0;  stall_pct <= 0;  end
        1: begin send_pct = 84; stall_pct <= 0;  end
        2: begin send_pct = 0;  stall_pct <= 84; end
        default: begin send_pct = 23; stall_pct <= 23; end
      endcase
      // long receiver hold-off while items keep coming, so the block backs up
      if (ph == 0 || ph == 4) hold_req <= hold_req + 1;
      run_random(PHASE_ITEMS);
    end

    wait_drained();
    $display("covered %0d sample items in %0d register phases with mixed stalls",
             items_sent, PHASES + 1);
    $display("checked %0d ok and %0d noisy points, %0d mismatches",
             ok_seen, noisy_seen, errors);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// File: touch_sample_average_calibrate.f
rtl/core/tsac_pkg.sv
rtl/core/tsac_if.sv
rtl/core/tsac_div.sv
rtl/core/tsac_mul.sv
rtl/core/touch_sample_average_calibrate.sv
sim/tsac_point_checker.sv
sim/touch_sample_average_calibrate_tb.sv
